// File: hdl/tbst_pkg.sv
`default_nettype none
package tbst_pkg;

	localparam int FRAC_BITS = 8;
	localparam int SAMPLE_W  = 16;
	localparam int Q_W       = SAMPLE_W + FRAC_BITS;
	localparam int STAGE_W   = 4;

	localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 16'hffff;
	localparam logic [Q_W-1:0]      Q_MAX      = Q_W'(SAMPLE_MAX) << FRAC_BITS;

	// input tdata: stage, frame_max, frame_min, raw_sample, pre_cmf_sample, baseline_in
	localparam int IN_W    = STAGE_W + 4 * SAMPLE_W + Q_W;
	localparam int S_TDATA_W = ((IN_W + 7) / 8) * 8;
	// output tdata: action, update_step, update_allowed, force_flag, reset_flag, baseline_out
	localparam int OUT_W   = 2 + SAMPLE_W + 3 + Q_W;
	localparam int M_TDATA_W = ((OUT_W + 7) / 8) * 8;

	localparam logic [STAGE_W-1:0] STG_STABLE   = 4'd0;
	localparam logic [STAGE_W-1:0] STG_RESET    = 4'd1;
	localparam logic [STAGE_W-1:0] STG_NOISY    = 4'd2;
	localparam logic [STAGE_W-1:0] STG_POST_A   = 4'd7;
	localparam logic [STAGE_W-1:0] STG_POST_B   = 4'd8;
	localparam logic [STAGE_W-1:0] STG_DEBOUNCE = 4'd9;

	localparam logic [1:0] CFG_RST_SRC = 2'd0;
	localparam logic [1:0] CFG_PEAK    = 2'd1;
	localparam logic [1:0] CFG_NFMS    = 2'd2;

	typedef enum logic [1:0] {
		ACT_HOLD   = 2'd0,
		ACT_UPDATE = 2'd1,
		ACT_RESET  = 2'd2,
		ACT_FORCED = 2'd3
	} act_t;

endpackage
`default_nettype wire

// File: hdl/tbst_track.sv
`default_nettype none
module tbst_track (
	input  wire logic [tbst_pkg::Q_W-1:0]             base,
	input  wire logic [tbst_pkg::SAMPLE_W-1:0]        sample,
	input  wire logic signed [tbst_pkg::SAMPLE_W-1:0] step,
	output logic [tbst_pkg::Q_W-1:0]                  result
);
	import tbst_pkg::*;

	logic [Q_W-1:0]        sample_q;
	logic [Q_W-1:0]        step_q;
	logic signed [Q_W:0]   delta;
	logic [Q_W-1:0]        mag;
	logic [Q_W:0]          up;
	logic [Q_W-1:0]        dn;
	logic                  hold;

	always_comb begin
		sample_q = Q_W'(sample) << FRAC_BITS;
		// non-positive step means no movement
		step_q   = (step[SAMPLE_W-1] == 1'b1) ? '0 : (Q_W'(step[SAMPLE_W-2:0]) << FRAC_BITS);
		delta    = $signed({1'b0, sample_q}) - $signed({1'b0, base});
		mag      = delta[Q_W] ? Q_W'(-delta) : delta[Q_W-1:0];
		hold     = (step_q == '0) || (mag < step_q);
		up       = {1'b0, base} + {1'b0, step_q};
		dn       = base - step_q;
		if (hold) begin
			result = base;
		end else if (!delta[Q_W]) begin
			result = (up > {1'b0, Q_MAX}) ? Q_MAX : up[Q_W-1:0];
		end else if (base < step_q) begin
			result = '0;
		end else begin
			result = (dn > Q_MAX) ? Q_MAX : dn;
		end
	end

endmodule
`default_nettype wire

// File: hdl/touch_baseline_stage_tracker.sv
`default_nettype none
// An item passes the input register and then the result register; it moves on from the
// input register whenever the result register is empty or its result is being taken.
// Throughput: one item per cycle; an item is still taken into an empty input register while
// a result waits, and input stalls only when both registers hold items and m_tready is low.
// Reset (arst_n low, asynchronous): pipeline empty, all configuration registers zero.
// Configuration writes are taken every cycle (cfg_ready is always high).
module touch_baseline_stage_tracker (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	// stage, frame_max, frame_min, raw_sample, pre_cmf_sample, baseline_in, zero pad
	input  wire logic [tbst_pkg::S_TDATA_W-1:0]  s_tdata,
	// touch_seen, quiet_frame
	input  wire logic [1:0]                      s_tuser,
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	// action, update_step, update_allowed, force_flag, reset_flag, baseline_out, zero pad
	output logic [tbst_pkg::M_TDATA_W-1:0]       m_tdata,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [1:0]                      cfg_index,
	input  wire logic [15:0]                     cfg_data
);
	import tbst_pkg::*;

	// configuration
	logic                       rst_src_q;
	logic [SAMPLE_W-1:0]        peak_q;
	logic signed [SAMPLE_W-1:0] nfms_q;

	// input stage
	logic                       v_s1;
	logic [STAGE_W-1:0]         stage_s1;
	logic signed [SAMPLE_W-1:0] max_s1;
	logic signed [SAMPLE_W-1:0] min_s1;
	logic                       has_s1;
	logic                       clean_s1;
	logic [SAMPLE_W-1:0]        raw_s1;
	logic [SAMPLE_W-1:0]        pre_s1;
	logic [Q_W-1:0]             base_s1;

	// result stage
	logic                       v_s2;
	act_t                       act_s2;
	logic signed [SAMPLE_W-1:0] step_s2;
	logic                       allowed_s2;
	logic                       force_s2;
	logic                       rst_s2;
	logic [Q_W-1:0]             newb_s2;

	logic                       adv;
	logic                       in_fire;

	logic [SAMPLE_W-1:0]        lim;
	logic [SAMPLE_W-1:0]        neg;
	logic signed [SAMPLE_W+1:0] max_x;
	logic signed [SAMPLE_W+1:0] min_x;
	logic signed [SAMPLE_W+1:0] lim_x;
	logic signed [SAMPLE_W+1:0] lim1_x;
	logic                       pass_l;
	logic                       pass_l1;
	logic [SAMPLE_W-1:0]        nfms_pos;
	logic [SAMPLE_W-1:0]        neg_16;
	logic [SAMPLE_W-1:0]        st_stable;
	logic [SAMPLE_W-1:0]        st_post;
	logic [SAMPLE_W-1:0]        st_deb;
	logic [SAMPLE_W-1:0]        t_min;

	act_t                       act_d;
	logic signed [SAMPLE_W-1:0] step_d;
	logic                       allowed_d;
	logic                       force_d;
	logic                       rst_d;
	logic [Q_W-1:0]             track_b;
	logic [Q_W-1:0]             newb_d;
	logic [SAMPLE_W-1:0]        rst_src;

	assign cfg_ready = 1'b1;
	assign adv       = !v_s2 || m_tready;
	assign s_tready  = !v_s1 || adv;
	assign in_fire   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rst_src_q <= 1'b0;
			peak_q    <= '0;
			nfms_q    <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_RST_SRC: rst_src_q <= cfg_data[0];
				CFG_PEAK:    peak_q    <= cfg_data;
				CFG_NFMS:    nfms_q    <= $signed(cfg_data);
				default:     ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (s_tready) begin
				v_s1 <= s_tvalid;
			end
			if (adv) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			stage_s1 <= s_tdata[STAGE_W-1:0];
			max_s1   <= $signed(s_tdata[STAGE_W +: SAMPLE_W]);
			min_s1   <= $signed(s_tdata[STAGE_W+SAMPLE_W +: SAMPLE_W]);
			raw_s1   <= s_tdata[STAGE_W+2*SAMPLE_W +: SAMPLE_W];
			pre_s1   <= s_tdata[STAGE_W+3*SAMPLE_W +: SAMPLE_W];
			base_s1  <= s_tdata[STAGE_W+4*SAMPLE_W +: Q_W];
			has_s1   <= s_tuser[0];
			clean_s1 <= s_tuser[1];
		end
		if (adv && v_s1) begin
			act_s2     <= act_d;
			step_s2    <= step_d;
			allowed_s2 <= allowed_d;
			force_s2   <= force_d;
			rst_s2     <= rst_d;
			newb_s2    <= newb_d;
		end
	end

	// limit checks and step candidates
	always_comb begin
		lim     = (peak_q == '0) ? SAMPLE_W'(1) : peak_q;
		neg     = min_s1[SAMPLE_W-1] ? SAMPLE_W'(-min_s1) : '0;
		max_x   = (SAMPLE_W+2)'(max_s1);
		min_x   = (SAMPLE_W+2)'(min_s1);
		lim_x   = $signed({2'b00, lim});
		lim1_x  = lim_x - (SAMPLE_W+2)'(1);
		pass_l  = (min_x >= -lim_x) && (max_x <= lim_x);
		pass_l1 = (min_x >= -lim1_x) && (max_x <= lim1_x);

		nfms_pos  = (nfms_q > 0) ? nfms_q : SAMPLE_W'(1);
		neg_16    = neg >> 4;
		t_min     = (neg_16 < (nfms_pos >> 2)) ? neg_16 : (nfms_pos >> 2);
		st_stable = (t_min == '0) ? SAMPLE_W'(1) : t_min;

		if ((lim >> 6) == '0) begin
			st_post = SAMPLE_W'(1);
		end else if ((lim >> 6) > SAMPLE_W'(255)) begin
			st_post = SAMPLE_W'(255);
		end else begin
			st_post = lim >> 6;
		end

		if (neg_16 < (lim >> 2)) begin
			st_deb = (neg_16 == '0) ? SAMPLE_W'(1) : neg_16;
		end else begin
			st_deb = ((lim >> 2) == '0) ? SAMPLE_W'(1) : (lim >> 2);
		end
	end

	always_comb begin
		act_d     = ACT_HOLD;
		step_d    = nfms_q;
		allowed_d = 1'b0;
		force_d   = 1'b0;
		rst_d     = 1'b0;
		case (stage_s1)
			STG_STABLE: begin
				allowed_d = pass_l && !has_s1 && clean_s1;
				if (min_s1[SAMPLE_W-1]) begin
					step_d = $signed(st_stable);
				end
				if (allowed_d) begin
					act_d = ACT_UPDATE;
				end
			end
			STG_RESET: begin
				rst_d = 1'b1;
				act_d = ACT_RESET;
			end
			STG_NOISY: begin
				if (!has_s1) begin
					rst_d = 1'b1;
					act_d = ACT_RESET;
				end
			end
			STG_POST_A, STG_POST_B: begin
				step_d    = $signed(st_post);
				allowed_d = !has_s1 && pass_l1;
				if (allowed_d) begin
					act_d = ACT_UPDATE;
				end
			end
			STG_DEBOUNCE: begin
				step_d    = $signed(st_deb);
				force_d   = 1'b1;
				// negative bound bypassed
				allowed_d = max_x <= $signed({2'b00, neg});
				if (allowed_d) begin
					act_d = ACT_FORCED;
				end
			end
			default: ;
		endcase
	end

	tbst_track u_track (
		.base   (base_s1),
		.sample (raw_s1),
		.step   (step_d),
		.result (track_b)
	);

	always_comb begin
		rst_src = rst_src_q ? pre_s1 : raw_s1;
		if (rst_d) begin
			newb_d = Q_W'(rst_src) << FRAC_BITS;
		end else if (act_d == ACT_UPDATE || act_d == ACT_FORCED) begin
			newb_d = track_b;
		end else begin
			newb_d = base_s1;
		end
	end

	assign m_tvalid = v_s2;
	assign m_tdata  = M_TDATA_W'({newb_s2, rst_s2, force_s2, allowed_s2, step_s2, act_s2});

	a_reset_stage: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && v_s1 && stage_s1 == STG_RESET) |=> (act_s2 == ACT_RESET && rst_s2))
		else $error("reset stage did not produce a reset item");

	a_debounce_force: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && v_s1 && stage_s1 == STG_DEBOUNCE) |=> force_s2)
		else $error("debounce stage without force flag");

	a_hold_passes: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && v_s1 && act_d == ACT_HOLD) |=> (newb_s2 == $past(base_s1)))
		else $error("hold changed the baseline");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> s_tready)
		else $error("empty input stage not ready");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && !m_tready) |=> (v_s2 && newb_s2 == $past(newb_s2)))
		else $error("stalled item lost or changed");

endmodule
`default_nettype wire

// File: tb/sv/tb_top.sv
module tb_top;
	import tbst_pkg::*;

	localparam int CYCLE_LIMIT        = 800000;
	localparam int RANDOM_PER_SETTING = 190;
	localparam int LATENCY            = 2;

	// stages the block treats as hold, no names in the package
	localparam logic [STAGE_W-1:0] STG_FORCED   = 4'd3;
	localparam logic [STAGE_W-1:0] STG_TOUCH_HI = 4'd6;
	localparam logic [STAGE_W-1:0] STG_SPARE_LO = 4'd10;
	localparam logic [STAGE_W-1:0] STG_SPARE_HI = 4'd15;

	typedef struct {
		logic [STAGE_W-1:0] stage;
		logic signed [15:0] max_sig;
		logic signed [15:0] min_sig;
		logic               has_sig;
		logic               clean;
		logic [15:0]        raw;
		logic [15:0]        pre;
		logic [Q_W-1:0]     base_q;
	} cell_in_t;

	typedef struct {
		act_t           action;
		logic [15:0]    step;
		logic           allowed;
		logic           frc;
		logic           rld;
		logic [Q_W-1:0] base_q;
	} cell_res_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	// stage, frame_max, frame_min, raw_sample, pre_cmf_sample, baseline_in, zero pad
	logic [S_TDATA_W-1:0] s_tdata   = '0;
	// touch_seen, quiet_frame
	logic [1:0]           s_tuser   = '0;
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	// action, update_step, update_allowed, force_flag, reset_flag, baseline_out, zero pad
	logic [M_TDATA_W-1:0] m_tdata;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [1:0]           cfg_index = '0;
	logic [15:0]          cfg_data  = '0;

	// shadow of the block's registers, all zero out of reset
	logic                 cfg_src_pre = 1'b0;
	logic [15:0]          cfg_peak    = '0;
	logic signed [15:0]   cfg_nfms    = '0;

	cell_res_t cell_results_due[$];
	int        mismatches   = 0;
	int        cells_sent   = 0;
	int        results_seen = 0;
	int        settings_run = 0;
	int        cycles       = 0;
	int        stall_left   = 0;
	bit        steady_flow  = 1'b0;

	touch_baseline_stage_tracker u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				cell_results_due.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	function automatic int imin(int a, int b);
		return (a < b) ? a : b;
	endfunction

	function automatic int imax(int a, int b);
		return (a > b) ? a : b;
	endfunction

	function automatic logic [15:0] sat16(int v);
		if (v > 32767)
			return 16'h7fff;
		if (v < -32768)
			return 16'h8000;
		return v[15:0];
	endfunction

	function automatic int pick_gap();
		int r;
		if (steady_flow)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic bit bounds_ok(int maxs, int mins, int bound, bit skip_neg);
		int b;
		b = (bound < 0) ? 0 : bound;
		return (skip_neg || mins >= -b) && maxs <= b;
	endfunction

	// one step toward the raw sample, hold inside one step, clamp to 0..Q_MAX in Q16.8
	function automatic longint step_toward(longint base, logic [15:0] sample, int stp);
		longint target, delta, step_q, mag, nb;
		target = longint'(sample) << FRAC_BITS;
		delta  = target - base;
		step_q = (stp > 0) ? (longint'(stp) << FRAC_BITS) : 0;
		mag    = (delta < 0) ? -delta : delta;
		if (step_q == 0 || mag < step_q)
			return base;
		nb = (delta > 0) ? base + step_q : base - step_q;
		if (nb < 0)
			nb = 0;
		if (nb > longint'(Q_MAX))
			nb = longint'(Q_MAX);
		return nb;
	endfunction

	function automatic cell_res_t track_cell(cell_in_t c);
		cell_res_t r;
		int        nfms, lim, maxs, mins, neg, stp;
		bit        rld;
		nfms      = cfg_nfms;
		lim       = (cfg_peak == 16'd0) ? 1 : int'(cfg_peak);
		maxs      = c.max_sig;
		mins      = c.min_sig;
		neg       = (mins < 0) ? -mins : 0;
		stp       = nfms;
		rld       = 1'b0;
		r.action  = ACT_HOLD;
		r.allowed = 1'b0;
		r.frc     = 1'b0;
		case (c.stage)
			STG_STABLE: begin
				r.allowed = bounds_ok(maxs, mins, lim, 1'b0) && !c.has_sig && c.clean;
				if (mins < 0)
					stp = imax(imin(neg / 16, imax(nfms, 1) / 4), 1);
				if (r.allowed)
					r.action = ACT_UPDATE;
			end
			STG_RESET: rld = 1'b1;
			STG_NOISY: rld = !c.has_sig;
			STG_POST_A, STG_POST_B: begin
				stp = imin(imax(lim / 64, 1), 255);
				r.allowed = !c.has_sig && bounds_ok(maxs, mins, lim - 1, 1'b0);
				if (r.allowed)
					r.action = ACT_UPDATE;
			end
			STG_DEBOUNCE: begin
				stp = imax(1, imin(neg / 16, lim / 4));
				r.frc = 1'b1;
				r.allowed = bounds_ok(maxs, mins, neg, 1'b1);
				if (r.allowed)
					r.action = ACT_FORCED;
			end
			default: ;
		endcase
		if (rld)
			r.action = ACT_RESET;
		r.rld  = rld;
		r.step = stp[15:0];
		if (rld)
			r.base_q = Q_W'(cfg_src_pre ? c.pre : c.raw) << FRAC_BITS;
		else if (r.action == ACT_UPDATE || r.action == ACT_FORCED)
			r.base_q = Q_W'(step_toward(longint'(c.base_q), c.raw, stp));
		else
			r.base_q = c.base_q;
		return r;
	endfunction

	function automatic cell_in_t mk_cell(logic [STAGE_W-1:0] stage, int maxs, int mins,
			bit has, bit clean, logic [15:0] raw, logic [15:0] pre, logic [Q_W-1:0] base);
		cell_in_t c;
		c.stage   = stage;
		c.max_sig = sat16(maxs);
		c.min_sig = sat16(mins);
		c.has_sig = has;
		c.clean   = clean;
		c.raw     = raw;
		c.pre     = pre;
		c.base_q  = base;
		return c;
	endfunction

	// mostly defined stages with signals near the current limits, the rest noise
	function automatic cell_in_t rand_cell();
		cell_in_t c;
		int       lim, span, r, mnv, bnd, span_q;
		longint   b;
		lim  = (cfg_peak == 16'd0) ? 1 : int'(cfg_peak);
		span = imin(lim, 32767);
		r = $urandom_range(0, 99);
		if (r < 25)
			c.stage = STG_STABLE;
		else if (r < 40)
			c.stage = $urandom_range(0, 1) ? STG_POST_A : STG_POST_B;
		else if (r < 60)
			c.stage = STG_DEBOUNCE;
		else if (r < 70)
			c.stage = STG_RESET;
		else if (r < 80)
			c.stage = STG_NOISY;
		else
			c.stage = STAGE_W'($urandom_range(0, 15));

		r = $urandom_range(0, 99);
		if (r < 55) begin
			c.min_sig = sat16(-int'($urandom_range(0, span)));
			c.max_sig = sat16(int'($urandom_range(0, span)));
		end else if (r < 75) begin
			// straddle whichever bound this stage checks
			c.min_sig = sat16(-span + int'($urandom_range(0, 2)) - 1);
			mnv = c.min_sig;
			if (c.stage == STG_DEBOUNCE)
				bnd = (mnv < 0) ? -mnv : 0;
			else if (c.stage == STG_POST_A || c.stage == STG_POST_B)
				bnd = lim - 1;
			else
				bnd = lim;
			c.max_sig = sat16(bnd + int'($urandom_range(0, 2)) - 1);
		end else begin
			c.min_sig = 16'($urandom);
			c.max_sig = 16'($urandom);
		end

		c.has_sig = ($urandom_range(0, 99) < 25);
		c.clean   = ($urandom_range(0, 99) < 80);
		c.raw     = 16'($urandom);
		c.pre     = 16'($urandom);

		r = $urandom_range(0, 99);
		if (r < 60) begin
			span_q = (r < 30) ? 1024 : (r < 50) ? (1 << 17) : (1 << 22);
			b = (longint'(c.raw) << FRAC_BITS) + $urandom_range(0, 2 * span_q) - span_q;
		end else if (r < 80) begin
			b = $urandom_range(0, 24'hffffff);
		end else if (r < 90) begin
			// around the top of the Q range, some above it
			b = longint'(Q_MAX) + $urandom_range(0, 255) - $urandom_range(0, 4096);
		end else begin
			b = $urandom_range(0, 4096);
		end
		if (b < 0)
			b = 0;
		if (b > 24'hffffff)
			b = 24'hffffff;
		c.base_q = b[Q_W-1:0];
		return c;
	endfunction

	task automatic report(string what, longint got, longint want);
		mismatches++;
		if (mismatches <= 50)
			$display("mismatch at cycle %0d: %s got %0h want %0h", cycles, what, got, want);
	endtask

	// result check first, then queue the prediction for an item taken at this edge
	always @(posedge clk) begin : port_watch
		cell_res_t got, want;
		cell_in_t  c;
		if (m_tvalid && m_tready) begin
			results_seen++;
			got.action  = act_t'(m_tdata[1:0]);
			got.step    = m_tdata[17:2];
			got.allowed = m_tdata[18];
			got.frc     = m_tdata[19];
			got.rld     = m_tdata[20];
			got.base_q  = m_tdata[44:21];
			if (cell_results_due.size() == 0) begin
				report("result with nothing due, baseline_out", got.base_q, 0);
			end else begin
				want = cell_results_due.pop_front();
				if (got.action !== want.action)
					report("action", got.action, want.action);
				if (got.step !== want.step)
					report("update_step", got.step, want.step);
				if (got.allowed !== want.allowed)
					report("update_allowed", got.allowed, want.allowed);
				if (got.frc !== want.frc)
					report("force_flag", got.frc, want.frc);
				if (got.rld !== want.rld)
					report("reset_flag", got.rld, want.rld);
				if (got.base_q !== want.base_q)
					report("baseline_out", got.base_q, want.base_q);
			end
		end
		if (s_tvalid && s_tready) begin
			c.stage   = s_tdata[3:0];
			c.max_sig = s_tdata[19:4];
			c.min_sig = s_tdata[35:20];
			c.raw     = s_tdata[51:36];
			c.pre     = s_tdata[67:52];
			c.base_q  = s_tdata[91:68];
			c.has_sig = s_tuser[0];
			c.clean   = s_tuser[1];
			cell_results_due.push_back(track_cell(c));
		end
		if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_RST_SRC: cfg_src_pre = cfg_data[0];
				CFG_PEAK:    cfg_peak = cfg_data;
				CFG_NFMS:    cfg_nfms = cfg_data;
				default: ;
			endcase
		end
	end

	always @(negedge clk) begin
		if (stall_left > 0) begin
			m_tready = 1'b0;
			stall_left--;
		end else begin
			m_tready = 1'b1;
			stall_left = pick_gap();
		end
	end

	task automatic send_cell(cell_in_t c);
		int gap;
		@(negedge clk);
		s_tvalid = 1'b1;
		s_tdata  = {4'd0, c.base_q, c.pre, c.raw, c.min_sig, c.max_sig, c.stage};
		s_tuser  = {c.clean, c.has_sig};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		cells_sent++;
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			s_tvalid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic wait_all_results();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (cell_results_due.size() != 0)
			@(negedge clk);
		repeat (LATENCY + 2) @(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic apply_setting(logic src, logic [15:0] peak, logic [15:0] nfms);
		wait_all_results();
		write_reg(CFG_RST_SRC, {15'd0, src});
		write_reg(CFG_PEAK, peak);
		write_reg(CFG_NFMS, nfms);
		settings_run++;
	endtask

	task automatic test_directed();
		// register reset values: peak 0 acts as 1, step 0, reload from raw
		send_cell(mk_cell(STG_STABLE, 0, 0, 0, 1, 16'h1234, 16'h0000, 24'h000000));
		send_cell(mk_cell(STG_STABLE, 1, -1, 0, 1, 16'h0010, 16'hffff, 24'h000100));
		send_cell(mk_cell(STG_RESET, 32767, -32768, 1, 0, 16'hffff, 16'h0000, 24'h123456));
		send_cell(mk_cell(STG_NOISY, 0, 0, 0, 1, 16'h00ff, 16'h5555, 24'hffffff));
		send_cell(mk_cell(STG_NOISY, 0, 0, 1, 1, 16'h00ff, 16'h5555, 24'hffffff));
		// forced, touch and spare stages all hold, out-of-range baseline passes through
		for (int s = STG_FORCED; s <= STG_TOUCH_HI; s++)
			send_cell(mk_cell(STAGE_W'(s), 0, 0, 0, 1, 16'h0000, 16'h0000, 24'hffffff));
		for (int s = STG_SPARE_LO; s <= STG_SPARE_HI; s++)
			send_cell(mk_cell(STAGE_W'(s), 0, 0, 0, 1, 16'hffff, 16'h0000, 24'hffffff));

		apply_setting(1'b1, 16'hffff, 16'h7fff);
		send_cell(mk_cell(STG_STABLE, 32767, -32768, 0, 1, 16'h0000, 16'h0000, 24'hffffff));
		send_cell(mk_cell(STG_STABLE, 0, 0, 0, 1, 16'hffff, 16'hffff, 24'hfffff0));
		send_cell(mk_cell(STG_RESET, 0, 0, 0, 0, 16'h0000, 16'hffff, 24'h000000));
		send_cell(mk_cell(STG_POST_A, 32767, -32768, 0, 0, 16'hffff, 16'h0000, 24'hff0000));
		send_cell(mk_cell(STG_POST_B, 0, 0, 1, 1, 16'h0000, 16'h0000, 24'h00ffff));
		send_cell(mk_cell(STG_DEBOUNCE, 32767, -32768, 1, 0, 16'hffff, 16'h0000, 24'h000000));
		send_cell(mk_cell(STG_DEBOUNCE, 1, 0, 0, 1, 16'h8000, 16'h0000, 24'h800000));

		// most negative step, with peak 1: updates on the configured step cannot move
		apply_setting(1'b0, 16'h0001, 16'h8000);
		send_cell(mk_cell(STG_STABLE, 0, 0, 0, 1, 16'h4000, 16'h0000, 24'h000000));
		send_cell(mk_cell(STG_STABLE, 1, -1, 0, 1, 16'h0000, 16'h0000, 24'h000200));
		send_cell(mk_cell(STG_STABLE, 0, 0, 0, 0, 16'hffff, 16'h0000, 24'h000000));
		send_cell(mk_cell(STG_POST_A, 0, 0, 0, 1, 16'h0002, 16'hffff, 24'h000000));
	endtask

	task automatic test_random_sweep();
		logic        srcs  [9] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0};
		logic [15:0] peaks [9] = '{16'hffff, 16'h0000, 16'h0001, 16'h0040, 16'h00ff,
			16'd1000, 16'h8000, 16'h0000, 16'h0000};
		logic [15:0] steps [9] = '{16'h7fff, 16'h8000, 16'h0001, 16'h0010, 16'h0000,
			16'hffff, 16'd200, 16'h0000, 16'h0000};
		for (int k = 7; k < 9; k++) begin
			srcs[k]  = 1'($urandom_range(0, 1));
			peaks[k] = 16'($urandom);
			steps[k] = 16'($urandom);
		end
		for (int k = 0; k < 9; k++) begin
			apply_setting(srcs[k], peaks[k], steps[k]);
			repeat (RANDOM_PER_SETTING) send_cell(rand_cell());
		end
	endtask

	task automatic test_steady_stream();
		apply_setting(1'b1, 16'($urandom_range(64, 4096)), 16'($urandom_range(1, 300)));
		steady_flow = 1'b1;
		repeat (120) send_cell(rand_cell());
		wait_all_results();
		steady_flow = 1'b0;
	endtask

	task automatic test_drain_midstream();
		apply_setting(1'b0, 16'd300, 16'd40);
		repeat (4) begin
			repeat (25) send_cell(rand_cell());
			wait_all_results();
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_random_sweep();
		test_steady_stream();
		test_drain_midstream();
		wait_all_results();
		if (cell_results_due.size() != 0)
			report("results never delivered", cell_results_due.size(), 0);
		$display("%0d cells sent, %0d results checked, %0d register settings, %0d mismatches",
			cells_sent, results_seen, settings_run, mismatches);
		$display("all 16 stages, both reset sources, limit edges, gaps and stalls on both ports");
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

// File: touch_baseline_stage_tracker.f
hdl/tbst_pkg.sv
hdl/tbst_track.sv
hdl/touch_baseline_stage_tracker.sv
tb/sv/tb_top.sv
